// ===== rtl/uecl_pkg.sv =====
// Package for the uptime and epoch clock: field widths, constants, the
// controller/datapath command and status structs and the month offset table.
// No dependencies.
`default_nettype none

package uecl_pkg;

    localparam int unsigned MS_W      = 11;
    localparam int unsigned TICK_W    = 10;
    localparam int unsigned SECS_W    = 32;
    localparam int unsigned NS_W      = 30;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 10;
    localparam int unsigned YEAR_W    = 12;
    localparam int unsigned DAYS_W    = 22;
    localparam int unsigned TOD_W     = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_TICK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RTC_PRESENT = 1'b1;

    localparam logic [1:0] CLK_UNIX     = 2'd0;
    localparam logic [1:0] CLK_MONOTONE = 2'd1;

    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_UNSUPPORTED = 1'b1;

    localparam logic [TICK_W-1:0] MS_PER_TICK_RST = 10'd10;
    localparam logic [MS_W-1:0]   MS_PER_SEC      = 11'd1000;
    localparam logic [19:0]       NS_PER_MS       = 20'd1000000;

    // ceil(2^24 / 400): exact floor(y / 400) for y below 4096
    localparam logic [15:0]             ERA_RECIP   = 16'd41944;
    localparam logic signed [13:0]      YEARS_ERA   = 14'sd400;
    localparam logic signed [21:0]      DAYS_ERA    = 22'sd146097;
    localparam logic signed [DAYS_W-1:0] EPOCH_DAYS = 22'sd719468;
    localparam logic signed [31:0]      SECS_DAY    = 32'sd86400;
    localparam logic [11:0]             SECS_HOUR   = 12'd3600;
    localparam logic [5:0]              SECS_MIN    = 6'd60;

    typedef struct packed {
        logic load;
        logic tick;
        logic yoe_en;
        logic days_en;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    // (153 * mm + 2) / 5 for the March-based month index
    function automatic logic [8:0] month_days(input logic [3:0] mm);
        logic [8:0] d;
        unique case (mm)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            4'd12:   d = 9'd367;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/uecl_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on uecl_pkg for field widths.
`default_nettype none

interface uecl_req_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic [1:0]                       clock_sel;
    logic [uecl_pkg::YEAR_W-1:0]      year;
    logic [3:0]                       month;
    logic [4:0]                       day;
    logic [4:0]                       hour;
    logic [5:0]                       minute;
    logic [5:0]                       second;

    modport source (output valid, command, clock_sel, year, month, day, hour, minute,
                    second, input ready);
    modport sink   (input valid, command, clock_sel, year, month, day, hour, minute,
                    second, output ready);
endinterface

interface uecl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [uecl_pkg::SECS_W-1:0]   seconds;
    logic [uecl_pkg::NS_W-1:0]     nanoseconds;
    logic                          status;

    modport source (output valid, seconds, nanoseconds, status, input ready);
    modport sink   (input valid, seconds, nanoseconds, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/uecl_ctrl.sv =====
// Sequencer for the clock block: accepts beats, steps the date conversion
// and hands results to the output register. Depends on uecl_pkg.
`default_nettype none

module uecl_ctrl (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    input  wire                       in_command,
    output logic                      in_ready,
    input  wire uecl_pkg::dp_stat_t   stat,
    output uecl_pkg::dp_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_YOE,
        ST_DAYS,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = accept;
        cmd.tick     = accept && !in_command;
        cmd.yoe_en   = (state_reg == ST_YOE);
        cmd.days_en  = (state_reg == ST_DAYS);
        cmd.out_load = (state_reg == ST_DONE) && stat.out_free;
        state_next   = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_command)
                begin
                    state_next = ST_YOE;
                end
            end
            ST_YOE:  state_next = ST_DAYS;
            ST_DAYS: state_next = ST_DONE;
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uecl_dp.sv =====
// Datapath: configuration registers, uptime counter, days-from-civil
// pipeline registers and the output register. Depends on uecl_pkg.
`default_nettype none

module uecl_dp (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire [uecl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [uecl_pkg::CFG_DAT_W-1:0]      cfg_wdata,
    input  wire uecl_pkg::dp_cmd_t             cmd,
    output uecl_pkg::dp_stat_t                 stat,
    input  wire [1:0]                          clock_sel,
    input  wire [uecl_pkg::YEAR_W-1:0]         year,
    input  wire [3:0]                          month,
    input  wire [4:0]                          day,
    input  wire [4:0]                          hour,
    input  wire [5:0]                          minute,
    input  wire [5:0]                          second,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [uecl_pkg::SECS_W-1:0]        out_seconds,
    output logic [uecl_pkg::NS_W-1:0]          out_nanoseconds,
    output logic                               out_status
);

    localparam int unsigned TOD_W = uecl_pkg::TOD_W;

    logic [uecl_pkg::TICK_W-1:0]        ms_per_tick_reg;
    logic                               rtc_present_reg;
    logic [uecl_pkg::MS_W-1:0]          uptime_ms_reg;
    logic [uecl_pkg::SECS_W-1:0]        uptime_sec_reg;

    logic [1:0]                         clock_sel_reg;
    logic signed [13:0]                 ys_reg;
    logic signed [4:0]                  era_reg;
    logic signed [9:0]                  doy_reg;
    logic [uecl_pkg::TOD_W-1:0]         tod_reg;
    logic [8:0]                         yoe_reg;
    logic signed [uecl_pkg::DAYS_W-1:0] era_days_reg;
    logic signed [uecl_pkg::DAYS_W-1:0] days_reg;
    logic                               out_valid_reg;
    logic [uecl_pkg::SECS_W-1:0]        seconds_reg;
    logic [uecl_pkg::NS_W-1:0]          ns_reg;
    logic                               status_reg;

    logic [uecl_pkg::MS_W-1:0]          ms_sum;
    logic                               early_month;
    logic [3:0]                         mm;
    logic signed [13:0]                 ys_in;
    logic [27:0]                        era_prod;
    logic signed [4:0]                  era_in;
    logic signed [9:0]                  doy_in;
    logic [uecl_pkg::TOD_W-1:0]         tod_in;
    logic signed [13:0]                 yoe_full;
    logic signed [21:0]                 era_days_full;
    logic [1:0]                         cent;
    logic signed [uecl_pkg::DAYS_W-1:0] doe;
    logic signed [53:0]                 day_secs;
    logic [uecl_pkg::SECS_W-1:0]        unix_secs;
    logic [30:0]                        ns_full;

    assign stat.out_free = !out_valid_reg || out_ready;

    // config and uptime
    assign ms_sum = uptime_ms_reg + {1'b0, ms_per_tick_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_per_tick_reg <= uecl_pkg::MS_PER_TICK_RST;
            rtc_present_reg <= 1'b0;
            uptime_ms_reg   <= '0;
            uptime_sec_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    uecl_pkg::CFG_MS_PER_TICK: ms_per_tick_reg <= cfg_wdata;
                    uecl_pkg::CFG_RTC_PRESENT: rtc_present_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.tick)
            begin
                if (ms_sum >= uecl_pkg::MS_PER_SEC)
                begin
                    uptime_ms_reg  <= '0;
                    uptime_sec_reg <= uptime_sec_reg + 32'd1;
                end
                else
                begin
                    uptime_ms_reg <= ms_sum;
                end
            end
        end
    end

    // load stage: shifted year, era, day of year, time of day
    assign early_month = (month <= 4'd2);
    assign mm          = early_month ? (month + 4'd9) : (month - 4'd3);
    assign ys_in       = $signed({2'b00, year}) - $signed({13'd0, early_month});
    assign era_prod    = ys_in[11:0] * uecl_pkg::ERA_RECIP;
    assign era_in      = ys_in[13] ? -5'sd1 : $signed({1'b0, era_prod[27:24]});
    assign doy_in      = $signed({1'b0, uecl_pkg::month_days(mm)})
                         + $signed({5'd0, day}) - 10'sd1;
    assign tod_in      = TOD_W'(hour) * TOD_W'(uecl_pkg::SECS_HOUR)
                         + TOD_W'(minute) * TOD_W'(uecl_pkg::SECS_MIN)
                         + TOD_W'(second);

    // year of era and era start
    assign yoe_full      = ys_reg - 14'(era_reg * uecl_pkg::YEARS_ERA);
    assign era_days_full = 22'(era_reg * uecl_pkg::DAYS_ERA);

    // day of era and days since epoch
    always_comb
    begin
        priority if (yoe_reg >= 9'd300) cent = 2'd3;
        else if (yoe_reg >= 9'd200)     cent = 2'd2;
        else if (yoe_reg >= 9'd100)     cent = 2'd1;
        else                            cent = 2'd0;
    end

    assign doe = $signed({4'd0, 18'(yoe_reg) * 18'd365})
                 + $signed({15'd0, yoe_reg[8:2]})
                 - $signed({20'd0, cent})
                 + 22'(doy_reg);

    // final seconds
    assign day_secs  = days_reg * uecl_pkg::SECS_DAY;
    assign unix_secs = day_secs[31:0] + {15'd0, tod_reg};
    assign ns_full   = {20'd0, uptime_ms_reg} * {11'd0, uecl_pkg::NS_PER_MS};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            clock_sel_reg <= clock_sel;
            ys_reg        <= ys_in;
            era_reg       <= era_in;
            doy_reg       <= doy_in;
            tod_reg       <= tod_in;
        end
        if (cmd.yoe_en)
        begin
            yoe_reg      <= yoe_full[8:0];
            era_days_reg <= era_days_full;
        end
        if (cmd.days_en)
        begin
            days_reg <= era_days_reg + doe - uecl_pkg::EPOCH_DAYS;
        end
        if (cmd.out_load)
        begin
            unique case (clock_sel_reg)
                uecl_pkg::CLK_MONOTONE:
                begin
                    seconds_reg <= uptime_sec_reg;
                    ns_reg      <= ns_full[29:0];
                    status_reg  <= uecl_pkg::STATUS_OK;
                end
                uecl_pkg::CLK_UNIX:
                begin
                    seconds_reg <= rtc_present_reg ? unix_secs : '0;
                    ns_reg      <= '0;
                    status_reg  <= uecl_pkg::STATUS_OK;
                end
                default:
                begin
                    seconds_reg <= '0;
                    ns_reg      <= '0;
                    status_reg  <= uecl_pkg::STATUS_UNSUPPORTED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_seconds     = seconds_reg;
    assign out_nanoseconds = ns_reg;
    assign out_status      = status_reg;

endmodule

`default_nettype wire

// ===== rtl/uptime_and_epoch_clock.sv =====
// Uptime counter and Unix epoch converter, top level.
// Depends on uecl_pkg, uecl_if, uecl_ctrl and uecl_dp.
//
// Usage:
//   in_ch  : request beats. command 0 is a timer tick (no response), command 1
//            reads the clock chosen by clock_sel; calendar fields feed the Unix
//            clock conversion.
//   out_ch : one response beat per read: seconds, nanoseconds, status.
//   cfg_*  : write-only registers, index 0 ms_per_tick, index 1 rtc_present;
//            write only while the block is idle.
// Timing:
//   A tick is applied at the edge it is accepted; the next beat can follow in
//   the next cycle. A read walks the date conversion through three sequencer
//   steps (year of era, day count, seconds) and its response is then loaded
//   into the output register; in_ch takes no new beat while a read is in its steps.
// Reset: uptime cleared, ms_per_tick = 10, rtc_present = 0, no response pending.
// Stall: the response waits in the output register; a following tick or read
//   is still accepted, and a second read holds in its last step until the
//   output register frees.
`default_nettype none

module uptime_and_epoch_clock (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire [uecl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [uecl_pkg::CFG_DAT_W-1:0]      cfg_wdata,
    uecl_req_if.sink                           in_ch,
    uecl_rsp_if.source                         out_ch
);

    uecl_pkg::dp_cmd_t  cmd;
    uecl_pkg::dp_stat_t stat;

    uecl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_command (in_ch.command),
        .in_ready   (in_ch.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    uecl_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .cmd             (cmd),
        .stat            (stat),
        .clock_sel       (in_ch.clock_sel),
        .year            (in_ch.year),
        .month           (in_ch.month),
        .day             (in_ch.day),
        .hour            (in_ch.hour),
        .minute          (in_ch.minute),
        .second          (in_ch.second),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_seconds     (out_ch.seconds),
        .out_nanoseconds (out_ch.nanoseconds),
        .out_status      (out_ch.status)
    );

endmodule

`default_nettype wire

// ===== tb/uecl_tb_pkg.sv =====
`timescale 1ns / 100ps
// Beat types and the uptime tracker class that predicts the clock's response beats.
// Depends on uecl_pkg for widths, clock ids, status codes and register indexes.
package uecl_tb_pkg;

    import uecl_pkg::*;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic              command;
        logic [1:0]        clock_sel;
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } time_req_t;

    typedef struct packed {
        logic [SECS_W-1:0] seconds;
        logic [NS_W-1:0]   nanoseconds;
        logic              status;
    } time_rsp_t;

    // days-from-civil, signed 64-bit, result taken mod 2^32
    function automatic logic [31:0] civil_to_unix(input time_req_t r);
        longint y;
        longint m;
        longint d;
        longint era;
        longint yoe;
        longint doy;
        longint doe;
        longint total;
        y = longint'(r.year);
        m = longint'(r.month);
        d = longint'(r.day);
        if (m <= 2)
            y = y - 1;
        era = ((y >= 0) ? y : y - 399) / 400;
        yoe = y - era * 400;
        doy = (153 * (m + ((m > 2) ? -3 : 9)) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        total = (era * 146097 + doe - 719468) * 86400 + longint'(r.hour) * 3600
                + longint'(r.minute) * 60 + longint'(r.second);
        return total[31:0];
    endfunction

    class uptime_tracker;
        logic [TICK_W-1:0] ms_per_tick;
        logic              rtc_present;
        logic [MS_W-1:0]   uptime_ms;
        logic [SECS_W-1:0] uptime_secs;
        time_rsp_t         pending_times[$];
        int                mismatches;

        function new();
            ms_per_tick = MS_PER_TICK_RST;
            rtc_present = 1'b0;
            uptime_ms   = '0;
            uptime_secs = '0;
            mismatches  = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] val);
            if (idx == CFG_MS_PER_TICK)
                ms_per_tick = val[TICK_W-1:0];
            else if (idx == CFG_RTC_PRESENT)
                rtc_present = val[0];
        endfunction

        function int pending();
            return pending_times.size();
        endfunction

        function void note_request(input time_req_t r);
            time_rsp_t   t;
            logic [63:0] ns;
            if (r.command == CMD_TICK)
            begin
                uptime_ms = uptime_ms + MS_W'(ms_per_tick);
                if (uptime_ms >= MS_PER_SEC)
                begin
                    uptime_secs = uptime_secs + 1;
                    uptime_ms   = '0;
                end
                return;
            end
            t = '0;
            t.status = STATUS_OK;
            if (r.clock_sel == CLK_MONOTONE)
            begin
                ns = 64'(uptime_ms) * 64'd1000000;
                t.seconds     = uptime_secs;
                t.nanoseconds = ns[NS_W-1:0];
            end
            else if (r.clock_sel == CLK_UNIX)
            begin
                if (rtc_present)
                    t.seconds = civil_to_unix(r);
            end
            else
            begin
                t.status = STATUS_UNSUPPORTED;
            end
            pending_times.push_back(t);
        endfunction

        function void check_response(input time_rsp_t got);
            time_rsp_t want;
            if (pending_times.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: secs=%0d ns=%0d status=%0d",
                             got.seconds, got.nanoseconds, got.status);
                return;
            end
            want = pending_times.pop_front();
            if (got.seconds !== want.seconds || got.nanoseconds !== want.nanoseconds
                || got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"response mismatch: exp secs=%0d ns=%0d status=%0d,",
                              " got secs=%0d ns=%0d status=%0d"},
                             want.seconds, want.nanoseconds, want.status,
                             got.seconds, got.nanoseconds, got.status);
            end
        endfunction
    endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top level testbench for uptime_and_epoch_clock: drives ticks and reads, writes registers
// between phases and checks every response beat. Depends on uecl_pkg, uecl_if, uecl_tb_pkg.
module tb;

    import uecl_pkg::*;
    import uecl_tb_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 163;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    uecl_req_if req ();
    uecl_rsp_if rsp ();

    uptime_tracker sb;
    bit            calm;
    bit            hold_go;
    int            quiet;

    uptime_and_epoch_clock dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (req),
        .out_ch    (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            sb.note_request('{req.command, req.clock_sel, req.year, req.month, req.day,
                              req.hour, req.minute, req.second});
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_response('{rsp.seconds, rsp.nanoseconds, rsp.status});
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // response side
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_go = 1'b0;
                rsp.ready <= 1'b1;
            end
            else
            begin
                rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
            end
        end
    end

    function automatic time_req_t cal(input logic cmd, input logic [1:0] id,
                                      input int y, input int mo, input int d,
                                      input int h, input int mi, input int s);
        time_req_t r;
        r.command   = cmd;
        r.clock_sel = id;
        r.year      = YEAR_W'(y);
        r.month     = 4'(mo);
        r.day       = 5'(d);
        r.hour      = 5'(h);
        r.minute    = 6'(mi);
        r.second    = 6'(s);
        return r;
    endfunction

    function automatic time_req_t random_request();
        time_req_t   r;
        int          sel;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        r   = raw[$bits(time_req_t)-1:0];
        sel = $urandom_range(99);
        r.command = (sel < 45) ? CMD_TICK : CMD_READ;
        sel = $urandom_range(99);
        if (sel < 50)
            r.clock_sel = CLK_UNIX;
        else if (sel < 88)
            r.clock_sel = CLK_MONOTONE;
        if ($urandom_range(99) < 85)
        begin
            r.year   = YEAR_W'($urandom_range(2199, 1900));
            r.month  = 4'($urandom_range(12, 1));
            r.day    = 5'($urandom_range(31, 1));
            r.hour   = 5'($urandom_range(23, 0));
            r.minute = 6'($urandom_range(59, 0));
            r.second = 6'($urandom_range(59, 0));
        end
        return r;
    endfunction

    task automatic send(input time_req_t r);
        req.valid     <= 1'b1;
        req.command   <= r.command;
        req.clock_sel <= r.clock_sel;
        req.year      <= r.year;
        req.month     <= r.month;
        req.day       <= r.day;
        req.hour      <= r.hour;
        req.minute    <= r.minute;
        req.second    <= r.second;
        do @(posedge clk); while (!req.ready);
        if (!calm && $urandom_range(99) < 19)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_settings(input logic [CFG_DAT_W-1:0] ms,
                                 input logic [CFG_DAT_W-1:0] rtc_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MS_PER_TICK;
        cfg_wdata <= ms;
        sb.write_reg(CFG_MS_PER_TICK, ms);
        @(posedge clk);
        cfg_index <= CFG_RTC_PRESENT;
        cfg_wdata <= rtc_word;
        sb.write_reg(CFG_RTC_PRESENT, rtc_word);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [CFG_DAT_W-1:0] ms_set[PHASES];
        logic                 rtc_set[PHASES];
        logic [CFG_DAT_W-1:0] rtc_word;

        sb            = new();
        calm          = 1'b0;
        hold_go       = 1'b0;
        quiet         = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        req.valid     = 1'b0;
        req.command   = CMD_TICK;
        req.clock_sel = CLK_UNIX;
        req.year      = '0;
        req.month     = '0;
        req.day       = '0;
        req.hour      = '0;
        req.minute    = '0;
        req.second    = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: 10 ms per tick, no RTC
        send(cal(CMD_READ, CLK_MONOTONE, 0, 0, 0, 0, 0, 0));
        send(cal(CMD_READ, CLK_UNIX, 2024, 6, 15, 12, 30, 45));
        send(cal(CMD_READ, 2'd2, 4095, 15, 31, 31, 63, 63));
        send(cal(CMD_READ, 2'd3, 2000, 1, 1, 0, 0, 0));
        send(cal(CMD_TICK, CLK_UNIX, 0, 0, 0, 0, 0, 0));
        send(cal(CMD_TICK, 2'd3, 4095, 15, 31, 31, 63, 63));
        send(cal(CMD_TICK, CLK_MONOTONE, 0, 0, 0, 0, 0, 0));
        send(cal(CMD_READ, CLK_MONOTONE, 0, 0, 0, 0, 0, 0));
        drain();

        load_settings(10'd1000, 10'h3FF);
        send(cal(CMD_TICK, CLK_UNIX, 0, 0, 0, 0, 0, 0));
        send(cal(CMD_READ, CLK_MONOTONE, 0, 0, 0, 0, 0, 0));
        send(cal(CMD_READ, CLK_UNIX, 1970, 1, 1, 0, 0, 0));
        send(cal(CMD_READ, CLK_UNIX, 2199, 12, 31, 23, 59, 59));
        send(cal(CMD_READ, CLK_UNIX, 1900, 1, 1, 0, 0, 0));
        send(cal(CMD_READ, CLK_UNIX, 2000, 2, 29, 23, 59, 59));
        send(cal(CMD_READ, CLK_UNIX, 2021, 0, 10, 1, 2, 3));
        send(cal(CMD_READ, CLK_UNIX, 2021, 15, 10, 1, 2, 3));
        send(cal(CMD_READ, CLK_UNIX, 2021, 3, 0, 0, 0, 0));
        send(cal(CMD_READ, CLK_UNIX, 0, 1, 1, 0, 0, 0));
        send(cal(CMD_READ, CLK_UNIX, 4095, 12, 31, 31, 63, 63));
        drain();

        load_settings(10'd0, 10'h001);
        send(cal(CMD_TICK, CLK_UNIX, 0, 0, 0, 0, 0, 0));
        send(cal(CMD_READ, CLK_MONOTONE, 0, 0, 0, 0, 0, 0));
        drain();

        load_settings(10'd1023, 10'h000);
        send(cal(CMD_TICK, CLK_UNIX, 0, 0, 0, 0, 0, 0));
        send(cal(CMD_READ, CLK_MONOTONE, 0, 0, 0, 0, 0, 0));
        drain();

        ms_set  = '{10'd1, 10'd999, 10'd1023, 10'd0, 10'd1000, 10'd10, 10'd0, 10'd0};
        rtc_set = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        ms_set[6] = CFG_DAT_W'($urandom_range(1000, 1));
        ms_set[7] = CFG_DAT_W'($urandom_range(200, 1));
        for (int p = 0; p < PHASES; p++)
        begin
            rtc_word    = CFG_DAT_W'($urandom);
            rtc_word[0] = rtc_set[p];
            load_settings(ms_set[p], rtc_word);
            calm = (p == 1);
            if (p == 2)
                hold_go = 1'b1;
            for (int i = 0; i < PHASE_BEATS; i++)
                send(random_request());
            drain();
        end
        calm = 1'b0;

        repeat (SETTLE) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
